>>> rtl/core/bbe_pkg.sv
// Shared types, widths and constants of the edge-normalized 3x3 box blur.
// Used by every file of the block; depends on nothing.
package bbe_pkg;

  // Pixel and channel widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;

  // Frame geometry
  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned FW_W          = 11;   // frame_width register
  localparam int unsigned FH_W          = 13;   // frame_height register
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned RESET_WIDTH   = 640;
  localparam int unsigned RESET_HEIGHT  = 480;
  localparam int unsigned IROW_W        = 13;   // input row runs to height + 1
  localparam int unsigned OROW_W        = 12;   // output row stays below height

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Opcode of an input word
  localparam logic OP_FLUSH = 1'b1;

  // Mean arithmetic: rounded sum times a 2^-15 scaled reciprocal
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // Result queue, power of two deep
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int unsigned RESULT_W  = PIX_W + 1;

  // Which sides of the window fall outside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } border_t;

  // One accepted item on its way to the line store
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             emit;
    border_t          border;
  } step_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } result_t;

  // Reciprocal of the neighbor count, scaled by 2^RECIP_SHIFT and rounded up
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] k;
    unique case (n)
      4'd1:    k = 16'd32768;
      4'd2:    k = 16'd16384;
      4'd3:    k = 16'd10923;
      4'd4:    k = 16'd8192;
      4'd6:    k = 16'd5462;
      4'd9:    k = 16'd3641;
      default: k = 16'd0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/bbe_in_if.sv
// Input channel of the box blur: valid/ready plus one pixel or flush word.
// Depends on bbe_pkg.
interface bbe_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [bbe_pkg::CH_W-1:0]  in_red;
  logic [bbe_pkg::CH_W-1:0]  in_green;
  logic [bbe_pkg::CH_W-1:0]  in_blue;

  modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

>>> rtl/core/bbe_out_if.sv
// Result channel of the box blur: valid/ready plus one blurred pixel word.
// Depends on bbe_pkg.
interface bbe_out_if;
  logic                      valid;
  logic                      ready;
  logic [bbe_pkg::CH_W-1:0]  out_red;
  logic [bbe_pkg::CH_W-1:0]  out_green;
  logic [bbe_pkg::CH_W-1:0]  out_blue;
  logic                      frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

>>> rtl/core/bbe_cfg_if.sv
// Register write channel of the box blur: valid/ready, register index, data.
// Depends on bbe_pkg.
interface bbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbe_pkg::CFG_IDX_W-1:0]   index;
  logic [bbe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/bbe_ctrl.sv
// Front end of the box blur: frame registers, input and output position
// counters, input handshake. Depends on bbe_pkg, bbe_in_if, bbe_cfg_if.
module bbe_ctrl #(
  parameter int unsigned MAX_WIDTH = bbe_pkg::DEF_MAX_WIDTH,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  bbe_in_if.sink           pixel,
  bbe_cfg_if.sink          cfg,
  input  logic             room,
  output logic             go,
  output logic [COL_W-1:0] col,
  output bbe_pkg::step_t   step
);
  localparam int unsigned WID_W = COL_W + 1;
  localparam int unsigned CMP_W = (WID_W > bbe_pkg::FW_W) ? WID_W : bbe_pkg::FW_W;
  localparam int unsigned RST_W = (bbe_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                  MAX_WIDTH : bbe_pkg::RESET_WIDTH;

  logic [WID_W-1:0]           width_act, width_next;
  logic [bbe_pkg::FH_W-1:0]   height_act, height_next;
  logic [bbe_pkg::IROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]           in_col, in_col_next;
  logic [bbe_pkg::OROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0]           out_col, out_col_next;
  logic [CMP_W-1:0]           raw_width;
  logic [bbe_pkg::FH_W-1:0]   raw_height;
  logic                       take, cfg_wr, cfg_clear, over, flush_skip, emit, col_end;
  bbe_pkg::border_t           border;

  // Handshakes
  assign pixel.ready = !rst && room;
  assign cfg.ready   = !rst;
  assign take        = pixel.valid && pixel.ready;
  assign cfg_wr      = cfg.valid && cfg.ready;
  assign cfg_clear   = cfg_wr && (cfg.index == bbe_pkg::REG_FRAME_WIDTH ||
                                  cfg.index == bbe_pkg::REG_FRAME_HEIGHT);

  // Clamp register writes into the supported frame size
  always_comb begin
    raw_width   = CMP_W'(cfg.data[bbe_pkg::FW_W-1:0]);
    raw_height  = cfg.data[bbe_pkg::FH_W-1:0];
    width_next  = width_act;
    height_next = height_act;
    if (cfg_wr && cfg.index == bbe_pkg::REG_FRAME_WIDTH) begin
      priority if (raw_width == '0) begin
        width_next = WID_W'(1);
      end else if (raw_width > CMP_W'(MAX_WIDTH)) begin
        width_next = WID_W'(MAX_WIDTH);
      end else begin
        width_next = WID_W'(raw_width);
      end
    end
    if (cfg_wr && cfg.index == bbe_pkg::REG_FRAME_HEIGHT) begin
      priority if (raw_height == '0) begin
        height_next = bbe_pkg::FH_W'(1);
      end else if (raw_height > bbe_pkg::FH_W'(bbe_pkg::HEIGHT_LIMIT)) begin
        height_next = bbe_pkg::FH_W'(bbe_pkg::HEIGHT_LIMIT);
      end else begin
        height_next = raw_height;
      end
    end
  end

  // Classify the word: past the last pixel it is a zero tick, before it a
  // flush word is dropped
  always_comb begin
    over          = in_row >= height_act;
    flush_skip    = (pixel.opcode == bbe_pkg::OP_FLUSH) && !over;
    go            = take && !flush_skip;
    emit          = (in_row >= bbe_pkg::IROW_W'(2)) ||
                    (in_row == bbe_pkg::IROW_W'(1) && in_col != '0);
    col_end       = (WID_W'(in_col) + WID_W'(1)) == width_act;
    border.top    = out_row == '0;
    border.bottom = (bbe_pkg::FH_W'(out_row) + bbe_pkg::FH_W'(1)) == height_act;
    border.left   = out_col == '0;
    border.right  = (WID_W'(out_col) + WID_W'(1)) == width_act;
    border.last   = border.bottom && border.right;
    col           = in_col;
    step.pix      = over ? '0 : {pixel.in_red, pixel.in_green, pixel.in_blue};
    step.emit     = emit;
    step.border   = border;
  end

  // Advance the positions; a register write or the frame's last result
  // returns them to the origin
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (cfg_clear || (go && emit && border.last)) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else if (go) begin
      if (col_end) begin
        in_col_next = '0;
        in_row_next = in_row + bbe_pkg::IROW_W'(1);
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
      if (emit) begin
        if (border.right) begin
          out_col_next = '0;
          out_row_next = out_row + bbe_pkg::OROW_W'(1);
        end else begin
          out_col_next = out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_act  <= WID_W'(RST_W);
      height_act <= bbe_pkg::FH_W'(bbe_pkg::RESET_HEIGHT);
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else begin
      width_act  <= width_next;
      height_act <= height_next;
      in_row     <= in_row_next;
      in_col     <= in_col_next;
      out_row    <= out_row_next;
      out_col    <= out_col_next;
    end
  end

endmodule

>>> rtl/core/bbe_line_mem.sv
// Line store and 3x3 window: one memory holds both stored rows per column,
// read at acceptance, written back in the next cycle. Depends on bbe_pkg.
module bbe_line_mem #(
  parameter int unsigned MAX_WIDTH = bbe_pkg::DEF_MAX_WIDTH,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [COL_W-1:0]                  col,
  input  bbe_pkg::step_t                    step,
  output logic                              win_valid,
  output logic [8:0][bbe_pkg::PIX_W-1:0]    win,
  output bbe_pkg::border_t                  win_border
);
  localparam int unsigned ENTRY_W = 2 * bbe_pkg::PIX_W;

  // Entry: {row two above, row one above}
  logic [ENTRY_W-1:0]        mem [MAX_WIDTH];
  logic [ENTRY_W-1:0]        rd_data, fwd_data, entry, wr_data;
  logic                      b_valid, fwd;
  logic [COL_W-1:0]          b_col;
  bbe_pkg::step_t            b_step;
  logic [bbe_pkg::PIX_W-1:0] upper, lower;

  // Take the column just written when the next word reads the same column
  always_comb begin
    entry   = fwd ? fwd_data : rd_data;
    upper   = entry[ENTRY_W-1:bbe_pkg::PIX_W];
    lower   = entry[bbe_pkg::PIX_W-1:0];
    wr_data = {lower, b_step.pix};
  end

  // Read at acceptance, write back in the next cycle
  always_ff @(posedge clk) begin
    if (go) begin
      rd_data <= mem[col];
    end
    if (b_valid) begin
      mem[b_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      b_col    <= col;
      b_step   <= step;
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd       <= 1'b0;
      win_valid <= 1'b0;
    end else begin
      b_valid   <= go;
      fwd       <= go && b_valid && (col == b_col);
      win_valid <= b_valid && b_step.emit;
    end
  end

  // Shift the window left and load the new right column
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= upper;
      win[5] <= lower;
      win[8] <= b_step.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      win_border <= b_step.border;
    end
  end

endmodule

>>> rtl/core/bbe_mean.sv
// Per-channel mean over the in-frame part of the window: masked sum with
// rounding offset, then multiply by the count's reciprocal. Depends on bbe_pkg.
module bbe_mean (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [8:0][bbe_pkg::PIX_W-1:0]  win,
  input  bbe_pkg::border_t                border,
  output logic                            valid,
  output bbe_pkg::result_t                res
);
  logic [2:0]                                row_ok, col_ok;
  logic [1:0]                                rows, cols;
  logic [3:0]                                n;
  logic [2:0][bbe_pkg::SUM_W-1:0]            sum, t_next, t;
  logic [bbe_pkg::RECIP_W-1:0]               k;
  logic                                      d_valid, d_last;
  logic [2:0][bbe_pkg::PROD_W-1:0]           prod;

  // Sum the in-frame neighbors and add half the count for rounding
  always_comb begin
    row_ok = {!border.bottom, 1'b1, !border.top};
    col_ok = {!border.right, 1'b1, !border.left};
    rows   = 2'd1 + 2'(!border.top) + 2'(!border.bottom);
    cols   = 2'd1 + 2'(!border.left) + 2'(!border.right);
    n      = 4'(rows) * 4'(cols);
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sum[ch] = sum[ch] + bbe_pkg::SUM_W'(
                      win[r*3 + c][(2 - ch)*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
          end
        end
      end
      t_next[ch] = sum[ch] + bbe_pkg::SUM_W'(n[3:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t      <= t_next;
      k      <= bbe_pkg::recip(n);
      d_last <= border.last;
    end
  end

  // Scale by the reciprocal; the quotient always fits one channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bbe_pkg::PROD_W'(t[ch]) * bbe_pkg::PROD_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid) begin
      res.red       <= prod[0][bbe_pkg::RECIP_SHIFT +: bbe_pkg::CH_W];
      res.green     <= prod[1][bbe_pkg::RECIP_SHIFT +: bbe_pkg::CH_W];
      res.blue      <= prod[2][bbe_pkg::RECIP_SHIFT +: bbe_pkg::CH_W];
      res.frame_end <= d_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      valid   <= 1'b0;
    end else begin
      d_valid <= take;
      valid   <= d_valid;
    end
  end

endmodule

>>> rtl/core/bbe_out_fifo.sv
// Result queue with credit count: a slot is booked when a result-making
// word is accepted, freed when the word leaves. Depends on bbe_pkg, bbe_out_if.
module bbe_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              reserve,
  input  logic              push,
  input  bbe_pkg::result_t  push_word,
  bbe_out_if.source         result,
  output logic              room
);
  localparam int unsigned PTR_W = $clog2(bbe_pkg::OUT_DEPTH);

  bbe_pkg::result_t            slots [bbe_pkg::OUT_DEPTH];
  bbe_pkg::result_t            head;
  logic [PTR_W-1:0]            rd_ptr, wr_ptr;
  logic [bbe_pkg::CNT_W-1:0]   count, count_next, owed, owed_next;
  logic                        pop;

  // Present the oldest word
  assign head             = slots[rd_ptr];
  assign result.valid     = count != '0;
  assign result.out_red   = head.red;
  assign result.out_green = head.green;
  assign result.out_blue  = head.blue;
  assign result.frame_end = head.frame_end;
  assign pop              = result.valid && result.ready;

  // Track stored words and booked slots
  always_comb begin
    count_next = count + bbe_pkg::CNT_W'(push) - bbe_pkg::CNT_W'(pop);
    owed_next  = owed + bbe_pkg::CNT_W'(reserve) - bbe_pkg::CNT_W'(pop);
    room       = owed < bbe_pkg::CNT_W'(bbe_pkg::OUT_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      owed   <= '0;
    end else begin
      count <= count_next;
      owed  <= owed_next;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

>>> rtl/core/box_blur_3x3_edge_normalized.sv
// Channel    | role   | word
// -----------+--------+-----------------------------------------------
// pixel      | sink   | opcode, in_red, in_green, in_blue
// result     | source | out_red, out_green, out_blue, frame_end
// cfg        | sink   | index (0 frame_width, 1 frame_height), data
//
// One word per clock sustained while pixel.ready stays high. A result reaches
// the queue head once the word that completes its window has passed line store
// read, window shift, masked sum, reciprocal multiply and queue write. The line
// store is one memory, MAX_WIDTH deep and 48 bits wide, read and written once per word.
// pixel.ready drops while 8 results are booked in the pipe and queue.
// Reset is synchronous; the line store is not cleared and needs no sweep.
module box_blur_3x3_edge_normalized #(
  parameter int unsigned MAX_WIDTH = bbe_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  bbe_in_if.sink      pixel,
  bbe_out_if.source   result,
  bbe_cfg_if.sink     cfg
);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic                             go, room, win_valid, res_valid;
  logic [COL_W-1:0]                 col;
  bbe_pkg::step_t                   step;
  logic [8:0][bbe_pkg::PIX_W-1:0]   win;
  bbe_pkg::border_t                 win_border;
  bbe_pkg::result_t                 res;

  bbe_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .cfg   (cfg),
    .room  (room),
    .go    (go),
    .col   (col),
    .step  (step)
  );

  bbe_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .col        (col),
    .step       (step),
    .win_valid  (win_valid),
    .win        (win),
    .win_border (win_border)
  );

  bbe_mean u_mean (
    .clk    (clk),
    .rst    (rst),
    .take   (win_valid),
    .win    (win),
    .border (win_border),
    .valid  (res_valid),
    .res    (res)
  );

  bbe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (go && step.emit),
    .push      (res_valid),
    .push_word (res),
    .result    (result),
    .room      (room)
  );

endmodule

>>> rtl/core/bbe_checker.sv
// Port-level checks of the box blur, bound to the top level.
// Depends on bbe_pkg and box_blur_3x3_edge_normalized.
module bbe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bbe_pkg::RESULT_W-1:0]   out_word
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // Input back-pressure only comes from a result backlog
  a_ready_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // No result can reach the port in the first cycles after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind box_blur_3x3_edge_normalized bbe_checker u_bbe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_word  ({result.out_red, result.out_green, result.out_blue, result.frame_end})
);

>>> test/bbe_blur_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the edge-normalized 3x3 box blur: predicts every blurred pixel word
// from the accepted pixel and register words and compares the result words.
// Depends on bbe_pkg and the bbe_in_if, bbe_out_if and bbe_cfg_if interfaces.
module bbe_blur_checker (
  input  logic        clk,
  input  logic        rst,
  bbe_in_if           pixel,
  bbe_out_if          result,
  bbe_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned pending
);
  import bbe_pkg::*;

  localparam int unsigned LINE_DEPTH   = DEF_MAX_WIDTH;
  localparam int unsigned CHANNEL_MAX  = 255;
  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the line stores, window, positions and geometry
  logic [PIX_W-1:0] upper_line [LINE_DEPTH];
  logic [PIX_W-1:0] lower_line [LINE_DEPTH];
  logic [PIX_W-1:0] window [9];
  int unsigned      in_row, in_col, out_row, out_col;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  result_t          expected_blur [$];

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == '0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  // Rounded mean of one channel over the window rows r0..r1, columns c0..c1
  function automatic logic [CH_W-1:0] window_mean(input int unsigned r0, r1, c0, c1, shift);
    int unsigned sum, n, q, r, c;
    sum = 0;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        sum += window[r * 3 + c][shift +: CH_W];
      end
    end
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    q = (2 * sum + n) / (2 * n);
    if (q > CHANNEL_MAX) q = CHANNEL_MAX;
    return CH_W'(q);
  endfunction

  // Advance the window by one accepted word and form the blurred pixel it completes
  task automatic blur_step(input logic op, input logic [PIX_W-1:0] pix_in,
                           output bit produced, output result_t blurred);
    int unsigned w, h, ir, ic, r0, r1, c0, c1;
    logic [PIX_W-1:0] pix;
    bit emit;
    produced = 1'b0;
    blurred  = '0;
    w   = active_width();
    h   = active_height();
    ir  = in_row;
    ic  = in_col;
    pix = '0;
    if (ir < h) begin
      // drop flush ticks while the frame still takes pixels
      if (op == OP_FLUSH) return;
      pix = pix_in;
    end
    if (ic >= LINE_DEPTH) ic = 0;

    for (int r = 0; r < 3; r++) begin
      window[r * 3]     = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2]      = upper_line[ic];
    window[5]      = lower_line[ic];
    window[8]      = pix;
    upper_line[ic] = lower_line[ic];
    lower_line[ic] = pix;

    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    in_row = ir;
    in_col = ic;
    if (!emit) return;

    // clip the window at the frame borders
    r0 = (out_row > 0) ? 0 : 1;
    r1 = (out_row + 1 < h) ? 2 : 1;
    c0 = (out_col > 0) ? 0 : 1;
    c1 = (out_col + 1 < w) ? 2 : 1;
    blurred.red   = window_mean(r0, r1, c0, c1, 2 * CH_W);
    blurred.green = window_mean(r0, r1, c0, c1, CH_W);
    blurred.blue  = window_mean(r0, r1, c0, c1, 0);
    produced = 1'b1;

    if (out_row + 1 >= h && out_col + 1 >= w) begin
      blurred.frame_end = 1'b1;
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    end else begin
      blurred.frame_end = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t got, want, blurred;
    bit      produced;
    if (rst) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      in_row     = 0;
      in_col     = 0;
      out_row    = 0;
      out_col    = 0;
      width_reg  = FW_W'(RESET_WIDTH);
      height_reg = FH_W'(RESET_HEIGHT);
      expected_blur.delete();
      fail_count = 0;
    end else begin
      // compare the result word with the oldest prediction
      if (result.valid && result.ready) begin
        got.red       = result.out_red;
        got.green     = result.out_green;
        got.blue      = result.out_blue;
        got.frame_end = result.frame_end;
        if (expected_blur.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result word with none expected: rgb %0d %0d %0d end %0b",
                     $time, got.red, got.green, got.blue, got.frame_end);
        end else begin
          want = expected_blur.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: blur mismatch: expected rgb %0d %0d %0d end %0b, got %0d %0d %0d end %0b",
                       $time, want.red, want.green, want.blue, want.frame_end,
                       got.red, got.green, got.blue, got.frame_end);
          end
        end
      end

      // a register write restarts the frame; stores and window hold
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg.data[FW_W-1:0];
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg.data[FH_W-1:0];
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
          end
          default: ;
        endcase
      end

      if (pixel.valid && pixel.ready) begin
        blur_step(pixel.opcode, {pixel.in_red, pixel.in_green, pixel.in_blue},
                  produced, blurred);
        if (produced) expected_blur.push_back(blurred);
      end
    end
    pending = expected_blur.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top of the box blur testbench: clock, reset, pixel, flush and register stimulus
// with random idling, watchdog and verdict. Depends on bbe_pkg, the three channel
// interfaces, box_blur_3x3_edge_normalized and bbe_blur_checker.
module tb;
  import bbe_pkg::*;

  localparam logic        OP_PIXEL      = ~OP_FLUSH;
  localparam int unsigned SETTLE_CYCLES = 16;    // pipe is 5 deep
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 700;

  logic        clk;
  logic        rst;
  bit          gaps_on;
  int unsigned ready_hold;
  int unsigned idle_cycles;
  int unsigned stepped_items;
  int unsigned fail_count;
  int unsigned pending;

  bbe_in_if  pixel ();
  bbe_out_if result ();
  bbe_cfg_if cfg ();

  box_blur_3x3_edge_normalized i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .cfg    (cfg)
  );

  bbe_blur_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .result     (result),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  // Channel values leaning toward the extremes
  function automatic logic [CH_W-1:0] channel_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned active_span(input int unsigned value, limit);
    if (value == 0) return 1;
    return (value > limit) ? limit : value;
  endfunction

  // Stall the result side at random
  always @(negedge clk) begin : result_stall
    if (ready_hold != 0) begin
      result.ready <= 1'b0;
      ready_hold--;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(4) == 0) ready_hold = gap_cycles();
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (pixel.valid && pixel.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one input word after a random gap and hold it until accepted
  task automatic send_word(input logic op, input logic [CH_W-1:0] red, green, blue);
    int unsigned gap;
    gap = gap_cycles();
    @(negedge clk);
    if (gap != 0) begin
      pixel.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel.valid    <= 1'b1;
    pixel.opcode   <= op;
    pixel.in_red   <= red;
    pixel.in_green <= green;
    pixel.in_blue  <= blue;
    do @(posedge clk); while (pixel.ready !== 1'b1);
  endtask

  task automatic send_random(input logic op);
    send_word(op, channel_value(), channel_value(), channel_value());
  endtask

  // Hold the sender until every predicted word is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    pixel.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= which;
    cfg.data  <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_value, h_value);
    write_reg(REG_FRAME_WIDTH, w_value);
    write_reg(REG_FRAME_HEIGHT, h_value);
  endtask

  // One w x h frame of random pixels, stray flush ticks mixed in, then the drain.
  // With allow_cut the frame may stop early, to be cut off by the next register write.
  task automatic run_frame(input int unsigned w, h, input bit allow_cut, output bit cut_short);
    int unsigned total, stop_at, pause_at;
    total     = w * h;
    stop_at   = total;
    cut_short = 1'b0;
    if (allow_cut && $urandom_range(7) == 0) begin
      stop_at   = $urandom_range(total - 1);
      cut_short = 1'b1;
    end
    pause_at = ($urandom_range(15) == 0) ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if ($urandom_range(11) == 0) send_random(OP_FLUSH);
      if (i == pause_at) settle();
      send_random(OP_PIXEL);
      stepped_items++;
    end
    if (cut_short) return;
    // drain the last row plus one with flush ticks or surplus pixels
    repeat (w + 1) begin
      send_random($urandom_range(1) ? OP_FLUSH : OP_PIXEL);
      stepped_items++;
    end
    if ($urandom_range(5) == 0) send_random(OP_FLUSH);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] w_value, h_value;
    int unsigned           w, h;
    bit                    cut_short;
    rst            = 1'b1;
    gaps_on        = 1'b1;
    pixel.valid    = 1'b0;
    pixel.opcode   = OP_PIXEL;
    pixel.in_red   = '0;
    pixel.in_green = '0;
    pixel.in_blue  = '0;
    result.ready   = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_FRAME_WIDTH;
    cfg.data       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry, 640 wide: part of the first row, no word may come out,
    // then cut by a write
    repeat (20) send_random(OP_PIXEL);

    // 3x3 checkerboard of full scale and zero; flush ticks before the last
    // pixel are ignored, surplus pixels after it drain like flush ticks
    set_geometry(3, 3);
    send_word(OP_FLUSH, '1, '1, '1);
    for (int i = 0; i < 9; i++) begin
      if (i == 8) send_word(OP_FLUSH, '1, '0, '1);
      send_word(OP_PIXEL, i[0] ? '1 : '0, i[0] ? '0 : '1, i[0] ? '1 : '0);
    end
    repeat (2) send_word(OP_FLUSH, '0, '0, '0);
    repeat (2) send_word(OP_PIXEL, '1, '1, '1);
    send_word(OP_FLUSH, '0, '0, '0);

    // zero width and height act as one: a single pixel frame
    set_geometry(0, 0);
    send_word(OP_PIXEL, 8'hFF, 8'h00, 8'hA5);
    repeat (2) send_word(OP_FLUSH, '0, '0, '0);

    // width data above the register is dropped: a 2 x 1 frame
    set_geometry(13'h1002, 1);
    send_word(OP_PIXEL, 8'h01, 8'h80, 8'hFE);
    send_word(OP_PIXEL, 8'h7F, 8'h02, 8'hFF);
    repeat (3) send_word(OP_FLUSH, '0, '0, '0);

    // width above MAX_WIDTH clamps to it: no word before a full row, then cut
    set_geometry(2047, 1);
    repeat (24) send_random(OP_PIXEL);

    // height above the limit clamps to it: a one pixel column far from its
    // bottom edge, then cut
    set_geometry(1, 8191);
    repeat (24) send_random(OP_PIXEL);

    // random geometries and frames, some back to back, some cut short
    cut_short     = 1'b1;
    stepped_items = 0;
    w             = 1;
    h             = 1;
    while (stepped_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(3) != 0);
      if (cut_short || $urandom_range(2) != 0) begin
        case ($urandom_range(9))
          0:       w_value = CFG_DATA_W'($urandom_range(1));
          1:       w_value = CFG_DATA_W'($urandom_range(40, 9));
          default: w_value = CFG_DATA_W'($urandom_range(8, 2));
        endcase
        case ($urandom_range(7))
          0:       h_value = CFG_DATA_W'($urandom_range(1));
          1:       h_value = CFG_DATA_W'($urandom_range(12, 6));
          default: h_value = CFG_DATA_W'($urandom_range(5, 2));
        endcase
        set_geometry(w_value, h_value);
        w = active_span(w_value, DEF_MAX_WIDTH);
        h = active_span(h_value, HEIGHT_LIMIT);
      end
      run_frame(w, h, 1'b1, cut_short);
    end

    gaps_on = 1'b1;
    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
